// File: sv/tdwc_pkg.sv
// ----------------------------------------------------------------------------
// tdwc_pkg
// Shared types, constants and the cell-width range table.
// ----------------------------------------------------------------------------
`default_nettype none

package tdwc_pkg;

    localparam int WIDTH_BITS  = 16;
    localparam int OUT_TDATA_W = ((WIDTH_BITS + 7) / 8) * 8;
    localparam int CP_W        = 21;

    localparam logic [7:0] ESC_BYTE      = 8'h1b;
    localparam logic [7:0] ESC_FINAL_LO  = 8'h40;
    localparam logic [7:0] ESC_FINAL_HI  = 8'h7e;

    typedef enum logic [2:0] {
        MODE_PLAIN     = 3'b001,
        MODE_ESC_FIRST = 3'b010,
        MODE_ESC_BODY  = 3'b100
    } t_mode;

    typedef struct packed {
        t_mode             mode;
        logic [1:0]        owed;
        logic [CP_W-1:0]   cp;
        logic [2:0]        fallback;
    } t_state;

    localparam t_state STATE_RESET = '{
        mode:     MODE_PLAIN,
        owed:     2'd0,
        cp:       '0,
        fallback: 3'd0
    };

    function automatic logic [1:0] cells_of(input logic [CP_W-1:0] cp);
        logic [1:0] w;
        w = 2'd1;
        if (cp < 21'h20 || (cp >= 21'h7f && cp < 21'ha0)) begin
            w = 2'd0;
        end else if ((cp >= 21'h0300 && cp <= 21'h036f) ||
                     (cp >= 21'h1ab0 && cp <= 21'h1aff) ||
                     (cp >= 21'h1dc0 && cp <= 21'h1dff) ||
                     (cp >= 21'h20d0 && cp <= 21'h20ff) ||
                     (cp >= 21'hfe20 && cp <= 21'hfe2f)) begin
            w = 2'd0;
        end else if ((cp >= 21'h1100 && cp <= 21'h115f) ||
                     (cp >= 21'h2e80 && cp <= 21'ha4cf) ||
                     (cp >= 21'hac00 && cp <= 21'hd7a3) ||
                     (cp >= 21'hf900 && cp <= 21'hfaff) ||
                     (cp >= 21'hfe10 && cp <= 21'hfe19) ||
                     (cp >= 21'hfe30 && cp <= 21'hfe6f) ||
                     (cp >= 21'hff00 && cp <= 21'hff60) ||
                     (cp >= 21'hffe0 && cp <= 21'hffe6) ||
                     (cp >= 21'h20000 && cp <= 21'h3fffd)) begin
            w = 2'd2;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// File: sv/terminal_display_width_counter.sv
// ----------------------------------------------------------------------------
// terminal_display_width_counter
// Terminal cell width of a UTF-8 string with escape sequences skipped.
// ----------------------------------------------------------------------------
// One byte per beat enters on the slave stream, tlast marking the string's
// last byte; one 16-bit saturating cell count leaves on the master stream for
// each string. Throughput is one byte per cycle: a byte is registered in the
// input stage, then decoded and summed into the running total, and the count is
// registered on the master stream when the last byte advances. Input stalls only
// when a last byte is staged while the previous count is still unread.
`default_nettype none

module terminal_display_width_counter
    import tdwc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [7:0]             i_s_axis_tdata,   // [7:0] text_byte
    input  wire logic                   i_s_axis_tlast,   // final_byte
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata    // [15:0] cell_width
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_last;
    t_state                r_state;
    logic [WIDTH_BITS-1:0] r_total;
    logic                  r_out_valid;
    logic [WIDTH_BITS-1:0] r_out_data;

    t_state                n_state;
    logic [2:0]            step_add;
    logic [WIDTH_BITS:0]   sum;
    logic [WIDTH_BITS-1:0] n_total;
    logic                  advance;

    tdwc_step u_step (
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_state (r_state),
        .o_state (n_state),
        .o_add   (step_add)
    );

    assign sum     = {1'b0, r_total} + {{(WIDTH_BITS-2){1'b0}}, step_add};
    assign n_total = sum[WIDTH_BITS] ? {WIDTH_BITS{1'b1}} : sum[WIDTH_BITS-1:0];
    assign advance = r_in_valid && (!r_in_last || !r_out_valid || i_m_axis_tready);

    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
            r_total <= '0;
        end else if (advance) begin
            if (r_in_last) begin
                r_state <= STATE_RESET;
                r_total <= '0;
            end else begin
                r_state <= n_state;
                r_total <= n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_data <= n_total;
        end
    end

    a_seq_only_in_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.owed != 2'd0 |-> r_state.mode == MODE_PLAIN)
        else $error("open UTF-8 sequence outside plain mode");

    a_fallback_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.owed != 2'd0 |-> r_state.fallback != 3'd0 && r_state.fallback <= 3'd3)
        else $error("fallback width out of range");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_total == '0 && r_state.owed == 2'd0 && r_out_valid)
        else $error("state not cleared after last beat");

    a_total_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_in_last |=> r_total >= $past(r_total))
        else $error("running total decreased");

endmodule

`default_nettype wire

// File: sv/tdwc_step.sv
// ----------------------------------------------------------------------------
// tdwc_step
// Next-state and cell increment for one byte of the string.
// ----------------------------------------------------------------------------
`default_nettype none

module tdwc_step
    import tdwc_pkg::*;
(
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    input  wire t_state     i_state,
    output t_state          o_state,
    output logic [2:0]      o_add
);

    t_state          nxt;
    logic            fresh;
    logic [2:0]      add;
    logic [CP_W-1:0] cp_next;
    logic [1:0]      byte_cells;

    always_comb begin
        nxt        = i_state;
        fresh      = 1'b0;
        add        = 3'd0;
        byte_cells = cells_of({13'd0, i_byte});
        cp_next    = {i_state.cp[CP_W-7:0], i_byte[5:0]};

        unique case (i_state.mode)
            MODE_ESC_FIRST: begin
                nxt.mode = MODE_ESC_BODY;
            end
            MODE_ESC_BODY: begin
                if (i_byte >= ESC_FINAL_LO && i_byte <= ESC_FINAL_HI) begin
                    nxt.mode = MODE_PLAIN;
                end
            end
            default: begin
                nxt.mode = MODE_PLAIN;
                if (i_state.owed != 2'd0) begin
                    if (i_byte[7:6] == 2'b10) begin
                        nxt.cp       = cp_next;
                        nxt.fallback = i_state.fallback + {1'b0, byte_cells};
                        nxt.owed     = i_state.owed - 2'd1;
                        if (i_state.owed == 2'd1) begin
                            add = {1'b0, cells_of(cp_next)};
                        end
                    end else begin
                        // broken sequence: flush lead and buffered bytes
                        add          = i_state.fallback;
                        nxt.owed     = 2'd0;
                        nxt.fallback = 3'd0;
                        nxt.cp       = '0;
                        fresh        = 1'b1;
                    end
                end else begin
                    fresh = 1'b1;
                end

                if (fresh) begin
                    priority if (i_byte == ESC_BYTE) begin
                        nxt.mode = MODE_ESC_FIRST;
                    end else if (!i_byte[7]) begin
                        add = add + {1'b0, byte_cells};
                    end else if (i_byte[7:5] == 3'b110) begin
                        nxt.cp       = {16'd0, i_byte[4:0]};
                        nxt.owed     = 2'd1;
                        nxt.fallback = {1'b0, byte_cells};
                    end else if (i_byte[7:4] == 4'b1110) begin
                        nxt.cp       = {17'd0, i_byte[3:0]};
                        nxt.owed     = 2'd2;
                        nxt.fallback = {1'b0, byte_cells};
                    end else if (i_byte[7:3] == 5'b11110) begin
                        nxt.cp       = {18'd0, i_byte[2:0]};
                        nxt.owed     = 2'd3;
                        nxt.fallback = {1'b0, byte_cells};
                    end else begin
                        add = add + {1'b0, byte_cells};
                    end
                end
            end
        endcase

        // string ends mid-sequence: count the pending bytes as lone characters
        if (i_last && nxt.owed != 2'd0) begin
            add = add + nxt.fallback;
        end
    end

    assign o_state = nxt;
    assign o_add   = add;

endmodule

`default_nettype wire
